// ===== design/can_hub_pkg.sv =====
// Package: shared types, codes and constants of the CAN motor command hub.
`timescale 1ns / 1ps

package can_hub_pkg;

	// Sizing
	localparam int MOTORS_PER_BUS = 8;
	localparam int BUS_COUNT      = 2;
	localparam int SLOT_W         = 3;
	localparam int BUS_W          = 1;
	localparam int GROUP_SLOTS    = 4;

	// Encoder and position arithmetic
	localparam logic [12:0] ENC_WRAP    = 13'd8191;
	localparam logic [17:0] MOD_MIN     = 18'd8192;
	localparam int          POS_FOLDS   = 4;

	// Register reset values
	localparam logic [10:0] FB_BASE_RST = 11'd513;
	localparam logic [10:0] LOW_ID_RST  = 11'd512;
	localparam logic [10:0] HIGH_ID_RST = 11'd511;
	localparam logic [17:0] MOD_RST     = 18'd157293;

	// Request codes
	typedef enum logic [1:0] {
		REQ_FEEDBACK    = 2'd0,
		REQ_SET_CURRENT = 2'd1,
		REQ_SEND        = 2'd2,
		REQ_READ        = 2'd3
	} req_e;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_OK      = 2'd0,
		KIND_IGNORED = 2'd1,
		KIND_TX      = 2'd2,
		KIND_RECORD  = 2'd3
	} kind_e;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_FB_BASE = 2'd0,
		CFG_LOW_ID  = 2'd1,
		CFG_HIGH_ID = 2'd2,
		CFG_MODULUS = 2'd3
	} cfg_reg_e;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_SEND2 = 2'd2
	} state_e;

	// One input item
	typedef struct packed {
		logic [1:0]         req_type;
		logic               bus_select;
		logic [10:0]        frame_id;
		logic [63:0]        payload;
		logic [2:0]         motor_index;
		logic signed [15:0] current_value;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0]         result_kind;
		logic [10:0]        out_frame_id;
		logic [63:0]        out_payload;
		logic [12:0]        angle;
		logic signed [15:0] speed;
		logic signed [15:0] measured_current;
		logic [7:0]         temperature;
		logic [17:0]        position;
		logic               last;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec_first;
		logic exec_second;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic two_results;
	} dp_status_t;

endpackage

// ===== design/can_hub_ctrl.sv =====
// Controller: sequences item capture, execution and the second send frame.
`timescale 1ns / 1ps

module can_hub_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  can_hub_pkg::dp_status_t status,
	output can_hub_pkg::ctrl_cmd_t  cmd,
	output logic                    busy
);

	can_hub_pkg::state_e state_q;
	can_hub_pkg::state_e state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= can_hub_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			can_hub_pkg::ST_IDLE: begin
				if (start) state_next = can_hub_pkg::ST_EXEC;
			end
			can_hub_pkg::ST_EXEC: begin
				state_next = status.two_results ? can_hub_pkg::ST_SEND2
				                                : can_hub_pkg::ST_IDLE;
			end
			can_hub_pkg::ST_SEND2: begin
				state_next = can_hub_pkg::ST_IDLE;
			end
			default: begin
				state_next = can_hub_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			can_hub_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.load_item = start;
			end
			can_hub_pkg::ST_EXEC: begin
				cmd.exec_first = 1'b1;
			end
			can_hub_pkg::ST_SEND2: begin
				cmd.exec_second = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/can_hub_dp.sv =====
// Datapath: configuration, motor tables, turn tracking and result register.
`timescale 1ns / 1ps

module can_hub_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  can_hub_pkg::item_t      item,
	input  logic                    cfg_valid,
	input  logic [1:0]              cfg_index,
	input  logic [17:0]             cfg_data,
	input  can_hub_pkg::ctrl_cmd_t  cmd,
	output can_hub_pkg::dp_status_t status,
	output logic                    result_valid,
	output can_hub_pkg::result_t    result
);

	localparam int SW = can_hub_pkg::SLOT_W;
	localparam int NB = can_hub_pkg::BUS_COUNT;
	localparam int NM = can_hub_pkg::MOTORS_PER_BUS;
	localparam int BUS_W_M1 = can_hub_pkg::BUS_W - 1;

	// Configuration registers
	logic [10:0] fb_base_q;
	logic [10:0] low_id_q;
	logic [10:0] high_id_q;
	logic [17:0] modulus_q;

	// Captured item
	can_hub_pkg::item_t item_q;

	// Per-motor tables, indexed [bus][slot]
	logic [12:0] angle_q   [NB][NM];
	logic [15:0] speed_q   [NB][NM];
	logic [15:0] current_q [NB][NM];
	logic [7:0]  temp_q    [NB][NM];
	logic [15:0] command_q [NB][NM];

	// Per-bus turn tracking
	logic [12:0] prev_angle_q [NB];
	logic [15:0] prev_speed_q [NB];
	logic [17:0] turn_pos_q   [NB];

	// Result register
	logic                 result_valid_q;
	can_hub_pkg::result_t result_q;

	// Decode of the captured item
	logic [BUS_W_M1:0] bus;
	logic        bus_ok;
	logic [10:0] fb_slot;
	logic        fb_match;
	logic [SW-1:0] fb_idx;
	logic        mi_ok;
	logic [12:0] deg;
	logic        is_fb_store;
	logic        is_set_store;

	assign bus          = item_q.bus_select;
	assign bus_ok       = int'(item_q.bus_select) < NB;
	assign fb_slot      = item_q.frame_id - fb_base_q;
	assign fb_match     = fb_slot < 11'(NM);
	assign fb_idx       = fb_slot[SW-1:0];
	assign mi_ok        = int'(item_q.motor_index) < NM;
	assign deg          = item_q.payload[60:48];
	assign is_fb_store  = cmd.exec_first && bus_ok && fb_match
	                      && (item_q.req_type == can_hub_pkg::REQ_FEEDBACK);
	assign is_set_store = cmd.exec_first && bus_ok && mi_ok
	                      && (item_q.req_type == can_hub_pkg::REQ_SET_CURRENT);

	assign status.two_results = bus_ok && (item_q.req_type == can_hub_pkg::REQ_SEND);

	// Multi-turn position step and fold
	logic [17:0]        mod_eff;
	logic signed [19:0] mod_s;
	logic signed [19:0] d_s;
	logic signed [19:0] prev_s;
	logic signed [19:0] wrap_s;
	logic signed [15:0] rpm;
	logic signed [19:0] pos;
	logic [17:0]        new_turn;

	always_comb begin
		mod_eff = (modulus_q < can_hub_pkg::MOD_MIN) ? can_hub_pkg::MOD_MIN : modulus_q;
		mod_s   = signed'({2'b00, mod_eff});
		d_s     = signed'({7'd0, deg});
		prev_s  = signed'({7'd0, prev_angle_q[bus]});
		wrap_s  = signed'({7'd0, can_hub_pkg::ENC_WRAP});
		rpm     = signed'(prev_speed_q[bus]);
		pos     = signed'({2'b00, turn_pos_q[bus]});
		if (rpm > 16'sd0 && d_s < prev_s) begin
			pos = pos + d_s + wrap_s - prev_s;
		end else if (rpm < 16'sd0 && d_s > prev_s) begin
			pos = pos + prev_s - wrap_s - d_s;
		end else begin
			pos = pos + d_s - prev_s;
		end
		for (int i = 0; i < can_hub_pkg::POS_FOLDS; i++) begin
			if (pos > mod_s) pos = pos - mod_s;
			else if (pos < 20'sd0) pos = pos + mod_s;
		end
		new_turn = pos[17:0];
	end

	// Send frames: four big-endian currents per group
	logic [63:0] group_low;
	logic [63:0] group_high;

	always_comb begin
		group_low  = '0;
		group_high = '0;
		for (int s = 0; s < can_hub_pkg::GROUP_SLOTS; s++) begin
			group_low  = {group_low[47:0],
			              (s < NM) ? command_q[bus][SW'(s)] : 16'd0};
			group_high = {group_high[47:0],
			              (s + can_hub_pkg::GROUP_SLOTS < NM)
			              ? command_q[bus][SW'(s + can_hub_pkg::GROUP_SLOTS)] : 16'd0};
		end
	end

	// Result of the first execution cycle
	can_hub_pkg::result_t res_first;
	can_hub_pkg::result_t res_second;

	always_comb begin
		res_first             = '0;
		res_first.last        = 1'b1;
		res_first.result_kind = can_hub_pkg::KIND_IGNORED;
		if (bus_ok) begin
			case (item_q.req_type)
				can_hub_pkg::REQ_FEEDBACK: begin
					if (fb_match) res_first.result_kind = can_hub_pkg::KIND_OK;
				end
				can_hub_pkg::REQ_SET_CURRENT: begin
					if (mi_ok) res_first.result_kind = can_hub_pkg::KIND_OK;
				end
				can_hub_pkg::REQ_SEND: begin
					res_first.result_kind  = can_hub_pkg::KIND_TX;
					res_first.out_frame_id = low_id_q;
					res_first.out_payload  = group_low;
					res_first.last         = 1'b0;
				end
				can_hub_pkg::REQ_READ: begin
					if (mi_ok) begin
						res_first.result_kind      = can_hub_pkg::KIND_RECORD;
						res_first.angle            = angle_q[bus][item_q.motor_index];
						res_first.speed            = signed'(speed_q[bus][item_q.motor_index]);
						res_first.measured_current =
							signed'(current_q[bus][item_q.motor_index]);
						res_first.temperature      = temp_q[bus][item_q.motor_index];
						res_first.position         = (item_q.motor_index == '0)
						                             ? turn_pos_q[bus] : 18'd0;
					end
				end
				default: begin
					res_first.result_kind = can_hub_pkg::KIND_IGNORED;
				end
			endcase
		end
	end

	// Second send frame
	always_comb begin
		res_second              = '0;
		res_second.result_kind  = can_hub_pkg::KIND_TX;
		res_second.out_frame_id = high_id_q;
		res_second.out_payload  = group_high;
		res_second.last         = 1'b1;
	end

	// Item capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q <= can_hub_pkg::FB_BASE_RST;
			low_id_q  <= can_hub_pkg::LOW_ID_RST;
			high_id_q <= can_hub_pkg::HIGH_ID_RST;
			modulus_q <= can_hub_pkg::MOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				can_hub_pkg::CFG_FB_BASE: fb_base_q <= cfg_data[10:0];
				can_hub_pkg::CFG_LOW_ID:  low_id_q  <= cfg_data[10:0];
				can_hub_pkg::CFG_HIGH_ID: high_id_q <= cfg_data[10:0];
				can_hub_pkg::CFG_MODULUS: modulus_q <= cfg_data;
				default: begin
					modulus_q <= modulus_q;
				end
			endcase
		end
	end

	// Motor tables and turn tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NB; b++) begin
				for (int s = 0; s < NM; s++) begin
					angle_q[b][s]   <= '0;
					speed_q[b][s]   <= '0;
					current_q[b][s] <= '0;
					temp_q[b][s]    <= '0;
					command_q[b][s] <= '0;
				end
				prev_angle_q[b] <= '0;
				prev_speed_q[b] <= '0;
				turn_pos_q[b]   <= '0;
			end
		end else begin
			if (is_fb_store) begin
				angle_q[bus][fb_idx]   <= deg;
				speed_q[bus][fb_idx]   <= item_q.payload[47:32];
				current_q[bus][fb_idx] <= item_q.payload[31:16];
				temp_q[bus][fb_idx]    <= item_q.payload[15:8];
				if (fb_idx == '0) begin
					prev_angle_q[bus] <= deg;
					prev_speed_q[bus] <= item_q.payload[47:32];
					turn_pos_q[bus]   <= new_turn;
				end
			end
			if (is_set_store) begin
				command_q[bus][item_q.motor_index] <= item_q.current_value;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.exec_first | cmd.exec_second;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec_first) result_q <= res_first;
		else if (cmd.exec_second) result_q <= res_second;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/can_motor_feedback_command_hub.sv =====
// Top level: CAN motor feedback decode and current command hub.
// Timing: start captures the item and moves the controller to its execute state,
// whose result is registered; a send item gives its second frame in the following cycle.
// Items: a new item is taken only in idle, after the execute state and, for a send item,
// the second send state; configuration writes always land.
// Reset: arst_n clears the controller, the motor tables, turn tracking and
// loads the register defaults; results are never stalled by the receiver.
`timescale 1ns / 1ps

module can_motor_feedback_command_hub (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  can_hub_pkg::item_t   item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [17:0]          cfg_data,
	output logic                 result_valid,
	output can_hub_pkg::result_t result
);

	can_hub_pkg::ctrl_cmd_t  cmd;
	can_hub_pkg::dp_status_t status;

	// Register writes are taken in any cycle
	assign cfg_ready = 1'b1;

	can_hub_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	can_hub_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	// An accepted transfer yields a result from its execute state
	a_start_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 result_valid)
		else $error("no result after accepted item");

	// The first send frame is followed at once by the closing frame
	a_send_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> (result_valid && result.last))
		else $error("second send frame missing");

	// Only transmit frames may be non-final
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind != can_hub_pkg::KIND_TX) |-> result.last)
		else $error("non-frame result without last");

	// The block is busy in the cycle after it accepts an item
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepted item");
`endif

endmodule
